>>> hdl/scp_pkg.sv
// scp_pkg: shared types and codes for the 2d simplex closest-point pipeline
// holds the result tag struct and the kept-vertex and count codes
// no dependencies
package scp_pkg;

  // kept-vertex masks, bit0 first vertex, bit1 second, bit2 third
  localparam logic [2:0] KEEP_A   = 3'b001;
  localparam logic [2:0] KEEP_B   = 3'b010;
  localparam logic [2:0] KEEP_C   = 3'b100;
  localparam logic [2:0] KEEP_AB  = 3'b011;
  localparam logic [2:0] KEEP_AC  = 3'b101;
  localparam logic [2:0] KEEP_BC  = 3'b110;
  localparam logic [2:0] KEEP_ABC = 3'b111;

  // vertex counts of a simplex
  localparam logic [1:0] COUNT_POINT = 2'd1;
  localparam logic [1:0] COUNT_SEG   = 2'd2;
  localparam logic [1:0] COUNT_TRI   = 2'd3;

  // result tag that travels with the nearest point
  typedef struct packed {
    logic [2:0] kept_mask;
    logic [1:0] new_count;
    logic       contains_origin;
    logic       degenerate;
  } tag_t;

endpackage

>>> hdl/scp_front.sv
// scp_front: first three stages, edge vectors, products and the six dot terms
// depends on nothing but the coordinate width parameter
// feeds scp_region
module scp_front #(
  parameter int CW = 24,
  localparam int W = 2 * CW + 3
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic [1:0]           n_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  output logic [1:0]           n_o,
  output logic [2:0][CW-1:0]   vx_o,
  output logic [2:0][CW-1:0]   vy_o,
  output logic [5:0][W-1:0]    d_o,
  output logic [W-1:0]         dseg_o,
  output logic [5:0][CW-1:0]   mag_o,
  output logic [5:0]           neg_o
);

  localparam int DW  = CW + 1;
  localparam int PMW = 2 * CW + 2;

  // stage 1 registers
  logic [1:0]           n1_q;
  logic [2:0][CW-1:0]   vx1_q, vy1_q;
  logic signed [DW-1:0] dir1_q [6];

  // stage 2 registers
  logic [1:0]            n2_q;
  logic [2:0][CW-1:0]    vx2_q, vy2_q;
  logic signed [PMW-1:0] p2_q [14];
  logic [5:0][CW-1:0]    mag2_d, mag2_q;
  logic [5:0]            neg2_d, neg2_q;

  // stage 3 registers
  logic [1:0]         n3_q;
  logic [2:0][CW-1:0] vx3_q, vy3_q;
  logic [5:0][W-1:0]  d3_q;
  logic [W-1:0]       dseg3_q;
  logic [5:0][CW-1:0] mag3_q;
  logic [5:0]         neg3_q;

  // edge directions: ab, ac, bc
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n1_q      <= n_i;
      vx1_q     <= {cx_i, bx_i, ax_i};
      vy1_q     <= {cy_i, by_i, ay_i};
      dir1_q[0] <= DW'(bx_i) - DW'(ax_i);
      dir1_q[1] <= DW'(by_i) - DW'(ay_i);
      dir1_q[2] <= DW'(cx_i) - DW'(ax_i);
      dir1_q[3] <= DW'(cy_i) - DW'(ay_i);
      dir1_q[4] <= DW'(cx_i) - DW'(bx_i);
      dir1_q[5] <= DW'(cy_i) - DW'(by_i);
    end
  end

  // magnitudes and signs of the edge components
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      neg2_d[k] = dir1_q[k][DW-1];
      mag2_d[k] = dir1_q[k][DW-1] ? CW'(-dir1_q[k]) : CW'(dir1_q[k]);
    end
  end

  // products of edge components with vertex coordinates
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      n2_q   <= n1_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      mag2_q <= mag2_d;
      neg2_q <= neg2_d;
      p2_q[0]  <= dir1_q[0] * $signed(vx1_q[0]);
      p2_q[1]  <= dir1_q[1] * $signed(vy1_q[0]);
      p2_q[2]  <= dir1_q[2] * $signed(vx1_q[0]);
      p2_q[3]  <= dir1_q[3] * $signed(vy1_q[0]);
      p2_q[4]  <= dir1_q[0] * $signed(vx1_q[1]);
      p2_q[5]  <= dir1_q[1] * $signed(vy1_q[1]);
      p2_q[6]  <= dir1_q[2] * $signed(vx1_q[1]);
      p2_q[7]  <= dir1_q[3] * $signed(vy1_q[1]);
      p2_q[8]  <= dir1_q[0] * $signed(vx1_q[2]);
      p2_q[9]  <= dir1_q[1] * $signed(vy1_q[2]);
      p2_q[10] <= dir1_q[2] * $signed(vx1_q[2]);
      p2_q[11] <= dir1_q[3] * $signed(vy1_q[2]);
      p2_q[12] <= dir1_q[0] * dir1_q[0];
      p2_q[13] <= dir1_q[1] * dir1_q[1];
    end
  end

  // dot terms d1..d6 against the negated vertices, squared length of ab
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n3_q   <= n2_q;
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      for (int j = 0; j < 6; j++) begin
        d3_q[j] <= -(W'(p2_q[2*j]) + W'(p2_q[2*j+1]));
      end
      dseg3_q <= W'(p2_q[12]) + W'(p2_q[13]);
    end
  end

  assign n_o    = n3_q;
  assign vx_o   = vx3_q;
  assign vy_o   = vy3_q;
  assign d_o    = d3_q;
  assign dseg_o = dseg3_q;
  assign mag_o  = mag3_q;
  assign neg_o  = neg3_q;

endmodule

>>> hdl/scp_region.sv
// scp_region: stages four to seven, region products and the region decision
// depends on scp_pkg for the result tag and codes
// takes the dot terms from scp_front and feeds scp_div
module scp_region #(
  parameter int CW = 24,
  localparam int W  = 2 * CW + 3,
  localparam int NW = W + 2
) (
  input  logic               clk_i,
  input  logic [3:0]         en_i,
  input  logic [1:0]         n_i,
  input  logic [2:0][CW-1:0] vx_i,
  input  logic [2:0][CW-1:0] vy_i,
  input  logic [5:0][W-1:0]  d_i,
  input  logic [W-1:0]       dseg_i,
  input  logic [5:0][CW-1:0] mag_i,
  input  logic [5:0]         neg_i,
  output logic [CW-1:0]      px_o,
  output logic [CW-1:0]      py_o,
  output logic [CW-1:0]      magx_o,
  output logic [CW-1:0]      magy_o,
  output logic               negx_o,
  output logic               negy_o,
  output logic [NW-1:0]      num_o,
  output logic [NW-1:0]      den_o,
  output scp_pkg::tag_t      tag_o
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;
  localparam int VW = PW + 1;
  localparam int SW = PW + 3;
  localparam int PL [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PR [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic [1:0]         n;
    logic [2:0][CW-1:0] vx;
    logic [2:0][CW-1:0] vy;
    logic [5:0][CW-1:0] mag;
    logic [5:0]         neg;
  } side_t;

  typedef struct packed {
    logic [W-1:0]   d1;
    logic [W-1:0]   d2;
    logic [W-1:0]   dseg;
    logic [W:0]     e13;
    logic [W:0]     e26;
    logic [W:0]     e43;
    logic [W:0]     e56;
    logic [W+1:0]   ebc;
  } nums_t;

  typedef struct packed {
    logic d1n, d1z, d2n, d2z, d3n, d3z, d6n, d6z;
    logic dsz, esn, e13z, e26z, e43n, e43z, e56n, e56z, ebcz;
  } flags_t;

  typedef enum logic [3:0] {
    R_A, R_B, R_C, R_SEG, R_AB, R_AC, R_BC, R_FACE, R_DEG
  } region_e;

  side_t  side_q [3];
  nums_t  nums_q [3];
  flags_t fl_q [3];

  // stage 4 partial products
  logic signed [2*HW-1:0]   hh_q [6];
  logic signed [HW+H:0]     hl_q [6];
  logic signed [HW+H:0]     lh_q [6];
  logic [2*H-1:0]           ll_q [6];
  // stage 5 full products, stage 6 region terms vc, vb, va
  logic signed [PW-1:0]     prod_q [6];
  logic signed [VW-1:0]     v_q [3];

  nums_t  nums4_d;
  flags_t fl4_d;
  nums_t  nums5_d;
  flags_t fl6_d;
  logic signed [HW-1:0] hil [6];
  logic signed [HW-1:0] hir [6];
  logic [H-1:0]         lol [6];
  logic [H-1:0]         lor [6];

  // differences, sign flags and operand halves for the region products
  always_comb begin
    nums4_d      = '0;
    nums4_d.d1   = d_i[0];
    nums4_d.d2   = d_i[1];
    nums4_d.dseg = dseg_i;
    nums4_d.e13  = (W+1)'($signed(d_i[0])) - (W+1)'($signed(d_i[2]));
    nums4_d.e26  = (W+1)'($signed(d_i[1])) - (W+1)'($signed(d_i[5]));
    nums4_d.e43  = (W+1)'($signed(d_i[3])) - (W+1)'($signed(d_i[2]));
    nums4_d.e56  = (W+1)'($signed(d_i[4])) - (W+1)'($signed(d_i[5]));
    fl4_d      = '0;
    fl4_d.d1n  = d_i[0][W-1];
    fl4_d.d1z  = (d_i[0] == '0);
    fl4_d.d2n  = d_i[1][W-1];
    fl4_d.d2z  = (d_i[1] == '0);
    fl4_d.d3n  = d_i[2][W-1];
    fl4_d.d3z  = (d_i[2] == '0);
    fl4_d.d6n  = d_i[5][W-1];
    fl4_d.d6z  = (d_i[5] == '0);
    fl4_d.dsz  = (dseg_i == '0);
    fl4_d.e13z = (nums4_d.e13 == '0);
    fl4_d.e26z = (nums4_d.e26 == '0);
    fl4_d.e43n = nums4_d.e43[W];
    fl4_d.e43z = (nums4_d.e43 == '0);
    fl4_d.e56n = nums4_d.e56[W];
    fl4_d.e56z = (nums4_d.e56 == '0);
    // segment: first vertex past the far end when d1 exceeds |ab|^2
    fl4_d.esn  = (((W+1)'($signed(dseg_i)) - (W+1)'($signed(d_i[0]))) >> W) != '0;
    for (int k = 0; k < 6; k++) begin
      hil[k] = $signed(d_i[PL[k]][W-1:H]);
      hir[k] = $signed(d_i[PR[k]][W-1:H]);
      lol[k] = d_i[PL[k]][H-1:0];
      lor[k] = d_i[PR[k]][H-1:0];
    end
  end

  // bc denominator and its zero flag
  always_comb begin
    nums5_d     = nums_q[0];
    nums5_d.ebc = (W+2)'($signed(nums_q[0].e43)) + (W+2)'($signed(nums_q[0].e56));
    fl6_d       = fl_q[1];
    fl6_d.ebcz  = (nums_q[1].ebc == '0);
  end

  // stages 4 to 6: partial products, products, region terms
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= '{n: n_i, vx: vx_i, vy: vy_i, mag: mag_i, neg: neg_i};
      nums_q[0] <= nums4_d;
      fl_q[0]   <= fl4_d;
      for (int k = 0; k < 6; k++) begin
        hh_q[k] <= hil[k] * hir[k];
        hl_q[k] <= hil[k] * $signed({1'b0, lor[k]});
        lh_q[k] <= $signed({1'b0, lol[k]}) * hir[k];
        ll_q[k] <= lol[k] * lor[k];
      end
    end
    if (en_i[1]) begin
      side_q[1] <= side_q[0];
      nums_q[1] <= nums5_d;
      fl_q[1]   <= fl_q[0];
      for (int k = 0; k < 6; k++) begin
        prod_q[k] <= (PW'(hh_q[k]) <<< (2 * H))
                   + ((PW'(hl_q[k]) + PW'(lh_q[k])) <<< H)
                   + PW'(ll_q[k]);
      end
    end
    if (en_i[2]) begin
      side_q[2] <= side_q[1];
      nums_q[2] <= nums_q[1];
      fl_q[2]   <= fl6_d;
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= VW'(prod_q[2*k]) - VW'(prod_q[2*k+1]);
      end
    end
  end

  logic [SW-1:0] vsum;
  logic [2:0]    vle;
  logic          sz;
  region_e       region;
  side_t         s7;
  nums_t         m7;
  flags_t        f7;

  // region decision: points and segments first, then triangles in the order a, b, c, ab, ac, bc, face
  always_comb begin
    s7   = side_q[2];
    m7   = nums_q[2];
    f7   = fl_q[2];
    vsum = SW'(v_q[0]) + SW'(v_q[1]) + SW'(v_q[2]);
    sz   = (vsum == '0);
    for (int k = 0; k < 3; k++) begin
      vle[k] = v_q[k][VW-1] | (v_q[k] == '0);
    end
    if (s7.n <= scp_pkg::COUNT_POINT) begin
      region = R_A;
    end else if (s7.n == scp_pkg::COUNT_SEG) begin
      if (f7.d1n)      region = R_A;
      else if (f7.esn) region = R_B;
      else if (f7.dsz) region = R_DEG;
      else             region = R_SEG;
    end else if ((f7.d1n | f7.d1z) && (f7.d2n | f7.d2z)) begin
      region = R_A;
    end else if (!f7.d3n && (f7.e43n | f7.e43z)) begin
      region = R_B;
    end else if (!f7.d6n && (f7.e56n | f7.e56z)) begin
      region = R_C;
    end else if (vle[0] && !f7.d1n && (f7.d3n | f7.d3z)) begin
      region = f7.e13z ? R_DEG : R_AB;
    end else if (vle[1] && !f7.d2n && (f7.d6n | f7.d6z)) begin
      region = f7.e26z ? R_DEG : R_AC;
    end else if (vle[2] && !f7.e43n && !f7.e56n) begin
      region = f7.ebcz ? R_DEG : R_BC;
    end else if (sz) begin
      region = R_DEG;
    end else begin
      region = R_FACE;
    end
  end

  logic [CW-1:0] px_d, py_d, magx_d, magy_d;
  logic          negx_d, negy_d;
  logic [NW-1:0] num_d, den_d;
  scp_pkg::tag_t tag_d;

  // base point, edge, projection ratio and tag per region
  always_comb begin
    px_d   = s7.vx[0];
    py_d   = s7.vy[0];
    magx_d = '0;
    magy_d = '0;
    negx_d = 1'b0;
    negy_d = 1'b0;
    num_d  = '0;
    den_d  = NW'(1);
    tag_d  = '{kept_mask: scp_pkg::KEEP_A, new_count: scp_pkg::COUNT_POINT,
               contains_origin: 1'b0, degenerate: 1'b0};
    unique case (region)
      R_A: ;
      R_B: begin
        px_d = s7.vx[1];
        py_d = s7.vy[1];
        tag_d.kept_mask = scp_pkg::KEEP_B;
      end
      R_C: begin
        px_d = s7.vx[2];
        py_d = s7.vy[2];
        tag_d.kept_mask = scp_pkg::KEEP_C;
      end
      R_SEG, R_AB: begin
        magx_d = s7.mag[0];
        magy_d = s7.mag[1];
        negx_d = s7.neg[0];
        negy_d = s7.neg[1];
        num_d  = NW'($signed(m7.d1));
        den_d  = (region == R_SEG) ? NW'($signed(m7.dseg)) : NW'($signed(m7.e13));
        tag_d.kept_mask = scp_pkg::KEEP_AB;
        tag_d.new_count = scp_pkg::COUNT_SEG;
      end
      R_AC: begin
        magx_d = s7.mag[2];
        magy_d = s7.mag[3];
        negx_d = s7.neg[2];
        negy_d = s7.neg[3];
        num_d  = NW'($signed(m7.d2));
        den_d  = NW'($signed(m7.e26));
        tag_d.kept_mask = scp_pkg::KEEP_AC;
        tag_d.new_count = scp_pkg::COUNT_SEG;
      end
      R_BC: begin
        px_d   = s7.vx[1];
        py_d   = s7.vy[1];
        magx_d = s7.mag[4];
        magy_d = s7.mag[5];
        negx_d = s7.neg[4];
        negy_d = s7.neg[5];
        num_d  = NW'($signed(m7.e43));
        den_d  = m7.ebc;
        tag_d.kept_mask = scp_pkg::KEEP_BC;
        tag_d.new_count = scp_pkg::COUNT_SEG;
      end
      R_FACE: begin
        px_d = '0;
        py_d = '0;
        tag_d.kept_mask       = scp_pkg::KEEP_ABC;
        tag_d.new_count       = scp_pkg::COUNT_TRI;
        tag_d.contains_origin = 1'b1;
      end
      R_DEG: begin
        tag_d.degenerate = 1'b1;
      end
      default: ;
    endcase
  end

  // stage 7 register
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      px_o   <= px_d;
      py_o   <= py_d;
      magx_o <= magx_d;
      magy_o <= magy_d;
      negx_o <= negx_d;
      negy_o <= negy_d;
      num_o  <= num_d;
      den_o  <= den_d;
      tag_o  <= tag_d;
    end
  end

endmodule

>>> hdl/scp_div.sv
// scp_div: projection back end, scale, one-bit-per-stage division, rounding
// depends on scp_pkg for the result tag
// takes the region decision from scp_region, holds the output register
module scp_div #(
  parameter int CW = 24,
  localparam int W  = 2 * CW + 3,
  localparam int NW = W + 2
) (
  input  logic             clk_i,
  input  logic [CW+3:0]    en_i,
  input  logic [CW-1:0]    px_i,
  input  logic [CW-1:0]    py_i,
  input  logic [CW-1:0]    magx_i,
  input  logic [CW-1:0]    magy_i,
  input  logic             negx_i,
  input  logic             negy_i,
  input  logic [NW-1:0]    num_i,
  input  logic [NW-1:0]    den_i,
  input  scp_pkg::tag_t    tag_i,
  output logic [CW-1:0]    near_x_o,
  output logic [CW-1:0]    near_y_o,
  output scp_pkg::tag_t    tag_o
);

  localparam int H2 = (NW + 1) / 2;
  localparam int RW = NW + CW;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          negx;
    logic          negy;
    logic [NW-1:0] den;
    scp_pkg::tag_t tag;
  } side_t;

  // scale stage partial products
  side_t                   s8_q;
  logic [H2+CW-1:0]        mlx_q, mly_q;
  logic [NW-H2+CW-1:0]     mhx_q, mhy_q;

  // division chain, index 0 is the scaled numerator
  side_t         side_q [CW+1];
  logic [RW-1:0] remx_q [CW+1];
  logic [RW-1:0] remy_q [CW+1];
  logic [CW-1:0] qx_q [CW+1];
  logic [CW-1:0] qy_q [CW+1];

  // rounding stage
  side_t         sr_q;
  logic [CW-1:0] qrx_q, qry_q;

  logic [RW:0]   tx [CW];
  logic [RW:0]   ty [CW];
  logic          upx, upy;
  logic signed [CW:0] sqx, sqy, sumx, sumy;

  // trial subtraction of the shifted divisor for each quotient bit
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      tx[i] = {1'b0, remx_q[i]} - ((RW+1)'(side_q[i].den) << (CW - 1 - i));
      ty[i] = {1'b0, remy_q[i]} - ((RW+1)'(side_q[i].den) << (CW - 1 - i));
    end
    upx  = ({remx_q[CW][NW-1:0], 1'b0} >= (NW+1)'(side_q[CW].den));
    upy  = ({remy_q[CW][NW-1:0], 1'b0} >= (NW+1)'(side_q[CW].den));
    sqx  = $signed({1'b0, qrx_q});
    sqy  = $signed({1'b0, qry_q});
    sumx = (CW+1)'($signed(sr_q.px)) + (sr_q.negx ? -sqx : sqx);
    sumy = (CW+1)'($signed(sr_q.py)) + (sr_q.negy ? -sqy : sqy);
  end

  always_ff @(posedge clk_i) begin
    // scale the ratio numerator by the edge magnitude, two halves
    if (en_i[0]) begin
      s8_q  <= '{px: px_i, py: py_i, negx: negx_i, negy: negy_i, den: den_i, tag: tag_i};
      mlx_q <= num_i[H2-1:0] * magx_i;
      mly_q <= num_i[H2-1:0] * magy_i;
      mhx_q <= num_i[NW-1:H2] * magx_i;
      mhy_q <= num_i[NW-1:H2] * magy_i;
    end
    // combine the halves
    if (en_i[1]) begin
      side_q[0] <= s8_q;
      remx_q[0] <= (RW'(mhx_q) << H2) + RW'(mlx_q);
      remy_q[0] <= (RW'(mhy_q) << H2) + RW'(mly_q);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
    end
    // restoring division, quotient bits from the top down
    for (int i = 0; i < CW; i++) begin
      if (en_i[2+i]) begin
        side_q[i+1] <= side_q[i];
        remx_q[i+1] <= tx[i][RW] ? remx_q[i] : tx[i][RW-1:0];
        remy_q[i+1] <= ty[i][RW] ? remy_q[i] : ty[i][RW-1:0];
        qx_q[i+1]   <= qx_q[i] | (CW'(!tx[i][RW]) << (CW - 1 - i));
        qy_q[i+1]   <= qy_q[i] | (CW'(!ty[i][RW]) << (CW - 1 - i));
      end
    end
    // round half away from zero on the magnitude
    if (en_i[CW+2]) begin
      sr_q  <= side_q[CW];
      qrx_q <= qx_q[CW] + CW'(upx);
      qry_q <= qy_q[CW] + CW'(upy);
    end
    // output register: base point plus signed offset
    if (en_i[CW+3]) begin
      near_x_o <= sumx[CW-1:0];
      near_y_o <= sumy[CW-1:0];
      tag_o    <= sr_q.tag;
    end
  end

endmodule

>>> hdl/simplex_closest_point_2d.sv
// simplex_closest_point_2d: top level, stream ports and pipeline valid control
// depends on scp_pkg, scp_front, scp_region and scp_div
//
// usage: one item on the slave stream is a simplex of one to three vertices
// in signed fixed point; one item comes out on the master stream per input
// item, in order: the nearest simplex point to the origin, the kept-vertex
// mask, the reduced vertex count, a contains-origin flag and a degenerate
// flag (zero projection divisor, first vertex returned).
// the pipeline stages are three of dot terms, four of region products and
// decision, two of scaling, one per quotient bit in the divider, one
// rounding stage and the output register.
// throughput is one item per cycle; each stage carries a valid bit and loads
// whenever some stage at or after it is empty, so bubbles are squeezed out and
// new items are taken while a finished result waits on the output.
// when the receiver stalls with every stage full, s_axis_tready_o drops and
// nothing is lost or repeated. reset clears all valid bits, so no item survives.
module simplex_closest_point_2d #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // vertex_count, ax, ay, bx, by, cx, cy from bit 0 up, zero padded
  input  logic [((6*COORD_BITS+2+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // near_x, near_y, kept_mask, new_count, contains_origin, degenerate from bit 0 up
  output logic [((2*COORD_BITS+7+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int CW    = COORD_BITS;
  localparam int W     = 2 * CW + 3;
  localparam int NW    = W + 2;
  localparam int NS    = CW + 11;
  localparam int OUT_W = ((2 * CW + 7 + 7) / 8) * 8;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] ready;

  // a stage loads when any stage at or after it is empty or the output drains
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ready[k] = m_axis_tready_i
               | ~&(valid_q | ((NS'(1) << k) - NS'(1)));
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ready[k]) begin
          valid_q[k] <= (k == 0) ? s_axis_tvalid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign s_axis_tready_o = ready[0];
  assign m_axis_tvalid_o = valid_q[NS-1];

  // front stages
  logic [1:0]         f_n;
  logic [2:0][CW-1:0] f_vx, f_vy;
  logic [5:0][W-1:0]  f_d;
  logic [W-1:0]       f_dseg;
  logic [5:0][CW-1:0] f_mag;
  logic [5:0]         f_neg;

  scp_front #(.CW(CW)) u_front (
    .clk_i  (clk_i),
    .en_i   (ready[2:0]),
    .n_i    (s_axis_tdata_i[1:0]),
    .ax_i   ($signed(s_axis_tdata_i[2 +: CW])),
    .ay_i   ($signed(s_axis_tdata_i[2 + CW +: CW])),
    .bx_i   ($signed(s_axis_tdata_i[2 + 2*CW +: CW])),
    .by_i   ($signed(s_axis_tdata_i[2 + 3*CW +: CW])),
    .cx_i   ($signed(s_axis_tdata_i[2 + 4*CW +: CW])),
    .cy_i   ($signed(s_axis_tdata_i[2 + 5*CW +: CW])),
    .n_o    (f_n),
    .vx_o   (f_vx),
    .vy_o   (f_vy),
    .d_o    (f_d),
    .dseg_o (f_dseg),
    .mag_o  (f_mag),
    .neg_o  (f_neg)
  );

  // region stages
  logic [CW-1:0]  r_px, r_py, r_magx, r_magy;
  logic           r_negx, r_negy;
  logic [NW-1:0]  r_num, r_den;
  scp_pkg::tag_t  r_tag;

  scp_region #(.CW(CW)) u_region (
    .clk_i  (clk_i),
    .en_i   (ready[6:3]),
    .n_i    (f_n),
    .vx_i   (f_vx),
    .vy_i   (f_vy),
    .d_i    (f_d),
    .dseg_i (f_dseg),
    .mag_i  (f_mag),
    .neg_i  (f_neg),
    .px_o   (r_px),
    .py_o   (r_py),
    .magx_o (r_magx),
    .magy_o (r_magy),
    .negx_o (r_negx),
    .negy_o (r_negy),
    .num_o  (r_num),
    .den_o  (r_den),
    .tag_o  (r_tag)
  );

  // projection and output stages
  logic [CW-1:0] near_x, near_y;
  scp_pkg::tag_t out_tag;

  scp_div #(.CW(CW)) u_div (
    .clk_i    (clk_i),
    .en_i     (ready[NS-1:7]),
    .px_i     (r_px),
    .py_i     (r_py),
    .magx_i   (r_magx),
    .magy_i   (r_magy),
    .negx_i   (r_negx),
    .negy_i   (r_negy),
    .num_i    (r_num),
    .den_i    (r_den),
    .tag_i    (r_tag),
    .near_x_o (near_x),
    .near_y_o (near_y),
    .tag_o    (out_tag)
  );

  assign m_axis_tdata_o = OUT_W'({out_tag.degenerate, out_tag.contains_origin,
                                  out_tag.new_count, out_tag.kept_mask,
                                  near_y, near_x});

  // a single kept vertex comes with a one-hot mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_tag.new_count == scp_pkg::COUNT_POINT)
      |-> $onehot(out_tag.kept_mask))
    else $error("point result without one-hot kept mask");

  // the face region returns the origin with all three vertices kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_tag.contains_origin
      |-> (near_x == '0) && (near_y == '0)
          && (out_tag.kept_mask == scp_pkg::KEEP_ABC)
          && (out_tag.new_count == scp_pkg::COUNT_TRI))
    else $error("face result not at the origin");

  // a degenerate item falls back to the first vertex alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_tag.degenerate
      |-> (out_tag.kept_mask == scp_pkg::KEEP_A)
          && (out_tag.new_count == scp_pkg::COUNT_POINT)
          && !out_tag.contains_origin)
    else $error("degenerate result with wrong reduction");

  // a full pipeline with a stalled output refuses new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while every stage is full");

endmodule
